@@ rtl/bezier_curve_evaluator_defines.svh @@
// Assertion macros used by the checker file.
`ifndef BEZIER_CURVE_EVALUATOR_DEFINES_SVH
`define BEZIER_CURVE_EVALUATOR_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define BCE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define BCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ rtl/bce_pkg.sv @@
// ---------------------------------------------------------------------------
// bce_pkg
// Shared types and constants for the Bezier curve evaluator.
// ---------------------------------------------------------------------------
package bce_pkg;

  localparam int MaxPoints = 128;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CoordW    = 32;
  localparam int ParamW    = 17;
  localparam int CountW    = 8;

  localparam logic [ParamW-1:0] TOne = ParamW'(65536);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;

endpackage

@@ rtl/bce_lerp.sv @@
// ---------------------------------------------------------------------------
// bce_lerp
// Q16.16 interpolation p + (((q - p) * t + 32768) >>> 16) with the product registered.
// ---------------------------------------------------------------------------
module bce_lerp import bce_pkg::*; (
  input  logic              clk,
  input  coord_t            p,
  input  coord_t            q,
  input  logic [ParamW-1:0] t,
  output coord_t            r
);

  logic signed [CoordW:0]          diff;
  logic signed [CoordW+ParamW+1:0] prod;
  coord_t                          p_d;

  assign diff = {q[CoordW-1], q} - {p[CoordW-1], p};

  always_ff @(posedge clk) begin
    prod <= diff * $signed({1'b0, t});
    p_d  <= p;
  end

  logic signed [CoordW+ParamW+1:0] rnd;
  assign rnd = prod + (CoordW+ParamW+2)'(32768);
  assign r   = p_d + CoordW'(rnd >>> 16);

endmodule

@@ rtl/bezier_curve_evaluator.sv @@
// ---------------------------------------------------------------------------
// bezier_curve_evaluator
// Bezier curve evaluation by the de Casteljau recurrence over a point RAM.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_stall carries cmd, point_index, coord_x,
// coord_y and curve_param. A load beat (cmd 0) writes one control point and
// completes with no result. An evaluate beat (cmd 1) copies the first n
// control points into a working RAM, then runs n(n-1)/2 interpolations for
// x and y in parallel, one at a time through one multiply stage per axis;
// each steps through RAM read, multiply and write states, the work RAM
// read-modify-write loop. A flush state then reads back the final point
// and a done state loads the result register.
// One evaluation is in flight at a time; in_stall is high while it runs.
// The result sits on out_valid/out_stall with curve_x and curve_y and holds
// while out_stall is high. New beats are taken while a result waits; an
// evaluation that finishes then waits until the result register is free.
// point_count is written via cfg_we/cfg_data, by the user only while idle;
// the block itself does not enforce this. It clamps to 2..128. Reset sets
// point_count to 100 and clears control state; the RAMs are not cleared.
// ---------------------------------------------------------------------------
module bezier_curve_evaluator import bce_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CountW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [6:0]        point_index,
  input  coord_t            coord_x,
  input  coord_t            coord_y,
  input  logic [ParamW-1:0] curve_param,
  output logic              out_valid,
  input  logic              out_stall,
  output coord_t            curve_x,
  output coord_t            curve_y
);

  typedef enum logic [2:0] {
    S_IDLE, S_COPY, S_RD, S_MUL, S_WR, S_FLUSH, S_DONE
  } state_t;

  state_t state;
  logic [CountW-1:0] point_count;
  logic [IdxW-1:0]   last;
  logic [IdxW-1:0]   idx, level;
  logic [ParamW-1:0] t;
  logic              copy_wr;
  logic [IdxW-1:0]   copy_idx;

  coord_t ctrl_x [MaxPoints];
  coord_t ctrl_y [MaxPoints];
  coord_t work_x [MaxPoints];
  coord_t work_y [MaxPoints];
  coord_t ctrl_rx, ctrl_ry;
  coord_t px, py, qx, qy;
  coord_t lx, ly;

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (point_count < CountW'(2))
      last = IdxW'(1);
    else if (point_count > CountW'(MaxPoints))
      last = IdxW'(MaxPoints - 1);
    else
      last = IdxW'(point_count - CountW'(1));
  end

  // Control RAM: load writes, copy reads.
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_LOAD) begin
      ctrl_x[point_index[IdxW-1:0]] <= coord_x;
      ctrl_y[point_index[IdxW-1:0]] <= coord_y;
    end
    ctrl_rx <= ctrl_x[idx];
    ctrl_ry <= ctrl_y[idx];
  end

  // Work RAM: two read ports (i, i+1), one write port.
  always_ff @(posedge clk) begin
    if (copy_wr) begin
      work_x[copy_idx] <= ctrl_rx;
      work_y[copy_idx] <= ctrl_ry;
    end else if (state == S_WR) begin
      work_x[idx] <= lx;
      work_y[idx] <= ly;
    end
    px <= work_x[idx];
    py <= work_y[idx];
    qx <= work_x[idx + IdxW'(1)];
    qy <= work_y[idx + IdxW'(1)];
  end

  bce_lerp u_lerp_x (.clk(clk), .p(px), .q(qx), .t(t), .r(lx));
  bce_lerp u_lerp_y (.clk(clk), .p(py), .q(qy), .t(t), .r(ly));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= CountW'(100);
      out_valid   <= 1'b0;
      copy_wr     <= 1'b0;
      idx         <= '0;
      level       <= '0;
    end else begin
      if (cfg_we) point_count <= cfg_data;
      copy_wr  <= 1'b0;
      copy_idx <= idx;
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && cmd == CMD_EVAL) begin
            t     <= (curve_param > TOne) ? TOne : curve_param;
            idx   <= '0;
            level <= last;
            state <= S_COPY;
          end
        end
        S_COPY: begin
          // ctrl read of idx lands next cycle, written the cycle after
          copy_wr <= 1'b1;
          if (idx == last) begin
            state <= S_RD;
          end else begin
            idx <= idx + IdxW'(1);
          end
        end
        S_RD: begin
          if (copy_wr) begin
            idx <= '0;         // let the final copy write land
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_WR;
        S_WR: begin
          if (idx + IdxW'(1) == level) begin
            if (level == IdxW'(1)) begin
              state <= S_FLUSH;
            end else begin
              level <= level - IdxW'(1);
              idx   <= '0;
              state <= S_RD;
            end
          end else begin
            idx   <= idx + IdxW'(1);
            state <= S_RD;
          end
        end
        // work RAM read of the final point lands in px/py here
        S_FLUSH: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            curve_x   <= px;
            curve_y   <= py;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/bce_checker.sv @@
// ---------------------------------------------------------------------------
// bce_checker
// Port-level checks on the evaluator handshakes.
// ---------------------------------------------------------------------------
`include "bezier_curve_evaluator_defines.svh"

module bce_checker import bce_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_stall,
  input logic   cmd,
  input logic   out_valid,
  input logic   out_stall,
  input coord_t curve_x
);

  `BCE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `BCE_ASSERT_NEXT(a_out_data, clk, rst, out_valid && out_stall, $stable(curve_x))
  `BCE_ASSERT_NEXT(a_eval_busy, clk, rst, in_valid && !in_stall && cmd == CMD_EVAL, in_stall)
  `BCE_ASSERT_NEXT(a_load_free, clk, rst, in_valid && !in_stall && cmd == CMD_LOAD, !in_stall)

endmodule

bind bezier_curve_evaluator bce_checker u_bce_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
  .out_valid(out_valid), .out_stall(out_stall), .curve_x(curve_x)
);

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// Bezier curve evaluator testbench
// Loads control points, sweeps point_count over its low clamp and small curve
// degrees, and checks every curve point against an in-bench de Casteljau
// predictor or a typed expectation under random idling and receiver hold-off.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bce_pkg::*;

  localparam int WatchdogLimit = 200000;
  localparam int FillPoints    = 8;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CountW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              cmd = CMD_LOAD;
  logic [6:0]        point_index = '0;
  coord_t            coord_x = '0;
  coord_t            coord_y = '0;
  logic [ParamW-1:0] curve_param = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  coord_t            curve_x;
  coord_t            curve_y;

  bezier_curve_evaluator u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  coord_t            pt_x [MaxPoints];
  coord_t            pt_y [MaxPoints];
  logic [CountW-1:0] active_count;
  coord_t            pending_x [$];
  coord_t            pending_y [$];
  bit                failed = 1'b0;
  bit                quiet = 1'b0;
  bit                hold_now = 1'b0;
  int                idle_cycles = 0;

  function automatic coord_t lerp(coord_t p, coord_t q, longint t);
    longint d;
    d = (longint'(q) - longint'(p)) * t + 32768;
    return coord_t'(longint'(p) + (d >>> 16));
  endfunction

  task automatic curve_point(input logic [ParamW-1:0] param,
                             output coord_t rx, output coord_t ry);
    coord_t wx [MaxPoints];
    coord_t wy [MaxPoints];
    int     n;
    longint t;
    n = (active_count < 2) ? 2 : (active_count > MaxPoints) ? MaxPoints : active_count;
    t = (param > TOne) ? longint'(TOne) : longint'(param);
    for (int i = 0; i < n; i++) begin
      wx[i] = pt_x[i];
      wy[i] = pt_y[i];
    end
    for (int lvl = n - 1; lvl > 0; lvl--) begin
      for (int i = 0; i < lvl; i++) begin
        wx[i] = lerp(wx[i], wx[i+1], t);
        wy[i] = lerp(wy[i], wy[i+1], t);
      end
    end
    rx = wx[0];
    ry = wy[0];
  endtask

  // Drives one beat; typed expectation used when use_typed is set.
  task automatic send_beat(input logic c, input logic [6:0] idx, input coord_t x,
                           input coord_t y, input logic [ParamW-1:0] t,
                           input bit use_typed, input coord_t tx, input coord_t ty);
    int     gap;
    coord_t ex, ey;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= c;
    point_index <= idx;
    coord_x <= x;
    coord_y <= y;
    curve_param <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (c == CMD_LOAD) begin
      pt_x[idx] = x;
      pt_y[idx] = y;
    end else begin
      if (use_typed) begin
        ex = tx;
        ey = ty;
      end else begin
        curve_point(t, ex, ey);
      end
      pending_x.push_back(ex);
      pending_y.push_back(ey);
    end
  endtask

  task automatic idle_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_x.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_count(input logic [CountW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    active_count = val;
  endtask

  function automatic logic [ParamW-1:0] rand_param();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return TOne;
      2: return ParamW'($urandom_range(65537, 131071));
      default: return ParamW'($urandom_range(0, 65536));
    endcase
  endfunction

  typedef struct {
    logic              c;
    logic [6:0]        idx;
    coord_t            x;
    coord_t            y;
    logic [ParamW-1:0] t;
    bit                typed;
    coord_t            ex;
    coord_t            ey;
  } beat_row_t;

  localparam coord_t CMin = 32'sh8000_0000;
  localparam coord_t CMax = 32'sh7fff_ffff;

  beat_row_t directed [] = '{
    '{CMD_LOAD, 7'd0,   CMin, CMax, '0, 0, '0, '0},
    '{CMD_LOAD, 7'd1,   CMax, CMin, '0, 0, '0, '0},
    '{CMD_EVAL, 7'd0,   '0, '0, 17'd0,      1, CMin, CMax},
    '{CMD_EVAL, 7'd127, '0, '0, 17'd65536,  1, CMax, CMin},
    '{CMD_EVAL, 7'd0,   '0, '0, 17'd131071, 1, CMax, CMin},
    '{CMD_EVAL, 7'd0,   '0, '0, 17'd65537,  1, CMax, CMin},
    '{CMD_EVAL, 7'd0,   '0, '0, 17'd32768,  0, '0, '0},
    '{CMD_EVAL, 7'd0,   '0, '0, 17'd1,      0, '0, '0},
    '{CMD_EVAL, 7'd0,   '0, '0, 17'd65535,  0, '0, '0},
    '{CMD_LOAD, 7'd0,   32'sh0001_0000, -32'sh0001_0000, '0, 0, '0, '0},
    '{CMD_LOAD, 7'd1,   -32'sh0000_0001, 32'sh0000_0001, '0, 0, '0, '0},
    '{CMD_EVAL, 7'd0,   '0, '0, 17'd32768,  0, '0, '0},
    '{CMD_EVAL, 7'd0,   '0, '0, 17'd21845,  0, '0, '0},
    '{CMD_LOAD, 7'd127, CMax, CMax, '0, 0, '0, '0},
    '{CMD_LOAD, 7'd1,   CMin, CMin, '0, 0, '0, '0},
    '{CMD_EVAL, 7'd0,   '0, '0, 17'd65536,  1, CMin, CMin}
  };

  logic [CountW-1:0] count_plan [] = '{8'd0, 8'd1, 8'd3, 8'd8, 8'd5, 8'd4,
                                       8'd7, 8'd2};

  // result checking
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_x.size() == 0) begin
        $display("%0t: curve point with none expected, got x=%0d y=%0d",
                 $time, curve_x, curve_y);
        failed = 1'b1;
      end else begin
        if (curve_x !== pending_x[0]) begin
          $display("%0t: curve_x expected %0d actual %0d", $time, pending_x[0], curve_x);
          failed = 1'b1;
        end
        if (curve_y !== pending_y[0]) begin
          $display("%0t: curve_y expected %0d actual %0d", $time, pending_y[0], curve_y);
          failed = 1'b1;
        end
        void'(pending_x.pop_front());
        void'(pending_y.pop_front());
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off while the sender keeps going
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && hold_now) begin
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
        out_stall <= 1'b0;
        held = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    active_count = 8'd100;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_count(8'd2);
    foreach (directed[i])
      send_beat(directed[i].c, directed[i].idx, directed[i].x, directed[i].y,
                directed[i].t, directed[i].typed, directed[i].ex, directed[i].ey);

    // fill every slot in use so no evaluation reads an unwritten point
    for (int i = 0; i < FillPoints; i++)
      send_beat(CMD_LOAD, 7'(i), coord_t'($urandom), coord_t'($urandom), '0, 0, '0, '0);

    foreach (count_plan[p]) begin
      idle_wait();
      write_count(count_plan[p]);
      if (count_plan[p] == 8'd3) hold_now = 1'b1;
      if (p == count_plan.size() - 1) quiet = 1'b1;
      for (int k = 0; k < 12; k++) begin
        if ($urandom_range(0, 1) == 0)
          send_beat(CMD_LOAD, 7'($urandom_range(0, 127)), coord_t'($urandom),
                    coord_t'($urandom), ParamW'($urandom), 0, '0, '0);
        else
          send_beat(CMD_EVAL, 7'($urandom), coord_t'($urandom), coord_t'($urandom),
                    rand_param(), 0, '0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_x.size() == 0);
    repeat (50) @(posedge clk);
    if (!failed) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
